[hw/rtl/scrf_pkg.sv]
package scrf_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RX_DONE = 2'd2,
    ACT_TX_DONE = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [13:0]       address;
    logic [31:0]       write_data;
    logic [CH_W-1:0]   channel;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } result_t;

  // Interrupt bookkeeping that the top level watches.
  typedef struct packed {
    logic       irq_level;
    logic       pending;
    logic [1:0] clear_cnt;
  } irq_stat_t;

  // Configuration register indexes.
  localparam logic CFG_FAMILY = 1'b0;
  localparam logic CFG_LINK   = 1'b1;

  // Global register addresses.
  localparam logic [13:0] ADDR_INT_STATUS = 14'h0000;
  localparam logic [13:0] ADDR_INT_MASK   = 14'h0010;
  localparam logic [13:0] ADDR_ENABLE     = 14'h0014;
  localparam logic [13:0] ADDR_ID_A       = 14'h0018;
  localparam logic [13:0] ADDR_ID_B       = 14'h007C;
  localparam logic [13:0] ADDR_OPTION     = 14'h2C00;
  localparam logic [13:0] ADDR_COMMAND    = 14'h2C24;
  localparam logic [13:0] ADDR_STATUS_W   = 14'h2C2C;

  // Offsets within a channel window.
  localparam logic [7:0] OFF_CRC      = 8'h00;
  localparam logic [7:0] OFF_CLK_SH   = 8'h40;
  localparam logic [7:0] OFF_CLK_DIV  = 8'h44;
  localparam logic [7:0] OFF_LINK     = 8'h60;
  localparam logic [7:0] OFF_CH_ID    = 8'h64;
  localparam logic [7:0] OFF_TX_FIRST = 8'h80;
  localparam logic [7:0] OFF_TX_LAST  = 8'h84;
  localparam logic [7:0] OFF_RX_FIRST = 8'h88;
  localparam logic [7:0] OFF_RX_LAST  = 8'h8C;
  localparam logic [7:0] OFF_CH_FIX   = 8'h90;

  // Fixed read values.
  localparam logic [31:0] VAL_ID_A     = 32'h7F7F7F7F;
  localparam logic [31:0] VAL_ID_B     = 32'h00000492;
  localparam logic [31:0] VAL_STATUS_W = 32'h0000FFFF;
  localparam logic [31:0] VAL_CH_ID    = 32'h0000007B;
  localparam logic [31:0] VAL_CH_FIX   = 32'h11111111;
  localparam logic [31:0] VAL_ALL_ONES = 32'hFFFFFFFF;

  // Command opcodes.
  localparam logic [7:0] OP_ENABLE   = 8'h00;
  localparam logic [7:0] OP_DIS_M0   = 8'h10;
  localparam logic [7:0] OP_DIS_M1_A = 8'h50;
  localparam logic [7:0] OP_DIS_M1_B = 8'h30;

endpackage

[hw/rtl/serial_ctrl_register_file.sv]
// Register file of a four-channel serial controller. Each request is a bus
// read, a bus write, or a receive or transmit frame-done event, and gives
// exactly one response carrying the read data (zero for writes, events and
// unmapped addresses) and the interrupt line level after the request. A
// request passes an input register and combinational decode and update before
// landing in the output register, and a new request is taken every cycle
// while the output side keeps up. The command opcode family and the
// link-attached bits are written through the cfg_ port and should only change
// while no request is in flight.
module serial_ctrl_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address[13:0], write_data[45:14], channel[47:46]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_data[31:0], irq_line[32], zero[39:33]
);

  scrf_pkg::item_t     req_item;
  scrf_pkg::item_t     item;
  scrf_pkg::result_t   result;
  scrf_pkg::result_t   res_data;
  scrf_pkg::irq_stat_t irq_stat;
  logic                item_valid;
  logic                advance;
  logic                load;

  assign req_item.action     = scrf_pkg::action_t'(in_tuser);
  assign req_item.address    = in_tdata[13:0];
  assign req_item.write_data = in_tdata[45:14];
  assign req_item.channel    = in_tdata[47:46];

  scrf_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_item   (req_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  scrf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .load      (load),
    .item      (item),
    .result    (result),
    .irq_stat  (irq_stat)
  );

  scrf_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .load       (load),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (res_data)
  );

  assign out_tdata = {7'b0, res_data.irq_line, res_data.read_data};

  // An unmasked pending interrupt always holds the line high.
  a_pending_level: assert property (@(posedge clk) disable iff (!rst_n)
    irq_stat.pending |-> irq_stat.irq_level)
    else $error("interrupt pending but line low");

  // The clear counter wraps before it can hold three.
  a_clear_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    irq_stat.clear_cnt != 2'd3)
    else $error("clear counter reached three");

  // A response reports the level that its request left behind.
  a_resp_level: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_tdata[32] == irq_stat.irq_level))
    else $error("response irq level differs from state");

  // With the output register empty the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

[hw/rtl/scrf_in_reg.sv]
module scrf_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  output logic             req_ready,
  input  scrf_pkg::item_t  req_item,
  input  logic             advance,
  output logic             item_valid,
  output scrf_pkg::item_t  item
);

  logic            in_v_r, in_v_nxt;
  scrf_pkg::item_t item_r;

  assign req_ready = !in_v_r || advance;

  always_comb begin
    if (req_valid && req_ready) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (req_valid && req_ready) begin
      item_r <= req_item;
    end
  end

  assign item_valid = in_v_r;
  assign item       = item_r;

endmodule

[hw/rtl/scrf_core.sv]
module scrf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_wdata,
  input  logic                load,
  input  scrf_pkg::item_t     item,
  output scrf_pkg::result_t   result,
  output scrf_pkg::irq_stat_t irq_stat
);

  localparam int N = scrf_pkg::NUM_CHANNELS;
  localparam int W = scrf_pkg::CH_W;

  logic        family_r;
  logic [3:0]  link_r;

  logic [31:0] status_r, status_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        level_r, level_nxt;
  logic [31:0] enable_r, enable_nxt;
  logic [31:0] option_r, option_nxt;
  logic [N-1:0] active_r, active_nxt;
  logic [31:0] crc_r [N], crc_nxt [N];
  logic [31:0] csh_r [N], csh_nxt [N];
  logic [31:0] cdiv_r [N], cdiv_nxt [N];
  logic [31:0] txf_r [N], txf_nxt [N];
  logic [31:0] txl_r [N], txl_nxt [N];
  logic [31:0] rxf_r [N], rxf_nxt [N];
  logic [31:0] rxl_r [N], rxl_nxt [N];

  logic [5:0]   win;
  logic [5:0]   win_m1;
  logic         in_win;
  logic [7:0]   off;
  logic         is_event;
  logic [W-1:0] sel_ch;
  logic         is_rd, is_wr;
  logic [31:0]  rd;
  logic         do_upd;
  logic [7:0]   cmd_op;
  logic [W-1:0] cmd_ch;
  logic [1:0]   cnt_inc;
  logic [31:0]  v;

  assign win      = item.address[13:8];
  assign win_m1   = win - 6'd1;
  assign in_win   = (win >= 6'd1) && (win <= 6'(N));
  assign off      = item.address[7:0];
  assign is_event = (item.action == scrf_pkg::ACT_RX_DONE) ||
                    (item.action == scrf_pkg::ACT_TX_DONE);
  // Events and channel windows never occur together, so one channel select
  // serves both; commands take their channel from the write data instead.
  assign sel_ch   = is_event ? item.channel : win_m1[W-1:0];
  assign is_rd    = (item.action == scrf_pkg::ACT_READ);
  assign is_wr    = (item.action == scrf_pkg::ACT_WRITE);
  assign v        = item.write_data;
  assign cmd_op   = v[19:12];
  assign cmd_ch   = v[W-1:0];

  // Read multiplexer.
  always_comb begin
    rd = '0;
    if (is_rd) begin
      if (in_win) begin
        unique case (off)
          scrf_pkg::OFF_CRC:      rd = crc_r[sel_ch];
          scrf_pkg::OFF_CLK_SH:   rd = csh_r[sel_ch];
          scrf_pkg::OFF_CLK_DIV:  rd = cdiv_r[sel_ch];
          scrf_pkg::OFF_TX_FIRST: rd = txf_r[sel_ch];
          scrf_pkg::OFF_TX_LAST:  rd = txl_r[sel_ch];
          scrf_pkg::OFF_RX_FIRST: rd = rxf_r[sel_ch];
          scrf_pkg::OFF_RX_LAST:  rd = rxl_r[sel_ch];
          scrf_pkg::OFF_LINK:     rd = link_r[sel_ch] ? scrf_pkg::VAL_ALL_ONES : '0;
          scrf_pkg::OFF_CH_ID:    rd = scrf_pkg::VAL_CH_ID;
          scrf_pkg::OFF_CH_FIX:   rd = scrf_pkg::VAL_CH_FIX;
          default:                rd = '0;
        endcase
      end else begin
        unique case (item.address)
          scrf_pkg::ADDR_INT_STATUS: rd = status_r;
          scrf_pkg::ADDR_INT_MASK:   rd = mask_r;
          scrf_pkg::ADDR_ENABLE:     rd = enable_r;
          scrf_pkg::ADDR_ID_A:       rd = scrf_pkg::VAL_ID_A;
          scrf_pkg::ADDR_ID_B:       rd = scrf_pkg::VAL_ID_B;
          scrf_pkg::ADDR_OPTION:     rd = option_r;
          scrf_pkg::ADDR_STATUS_W:   rd = scrf_pkg::VAL_STATUS_W;
          default:                   rd = '0;
        endcase
      end
    end
  end

  // Register updates for writes and events.
  always_comb begin
    status_nxt = status_r;
    mask_nxt   = mask_r;
    enable_nxt = enable_r;
    option_nxt = option_r;
    active_nxt = active_r;
    crc_nxt    = crc_r;
    csh_nxt    = csh_r;
    cdiv_nxt   = cdiv_r;
    txf_nxt    = txf_r;
    txl_nxt    = txl_r;
    rxf_nxt    = rxf_r;
    rxl_nxt    = rxl_r;
    do_upd     = 1'b0;

    if (is_wr) begin
      if (in_win) begin
        unique case (off)
          scrf_pkg::OFF_CRC:      crc_nxt[sel_ch]  = v;
          scrf_pkg::OFF_CLK_SH:   csh_nxt[sel_ch]  = v;
          scrf_pkg::OFF_CLK_DIV:  cdiv_nxt[sel_ch] = v;
          scrf_pkg::OFF_TX_FIRST: txf_nxt[sel_ch]  = v;
          scrf_pkg::OFF_TX_LAST:  txl_nxt[sel_ch]  = v;
          scrf_pkg::OFF_RX_FIRST: rxf_nxt[sel_ch]  = v;
          scrf_pkg::OFF_RX_LAST:  rxl_nxt[sel_ch]  = v;
          default: ;
        endcase
      end else begin
        unique case (item.address)
          scrf_pkg::ADDR_INT_STATUS: begin
            status_nxt = status_r & ~v;
            do_upd     = 1'b1;
          end
          scrf_pkg::ADDR_INT_MASK: begin
            mask_nxt = v;
            do_upd   = 1'b1;
          end
          scrf_pkg::ADDR_ENABLE: enable_nxt = v;
          scrf_pkg::ADDR_OPTION: option_nxt = v;
          scrf_pkg::ADDR_COMMAND: begin
            if (32'(cmd_ch) < N) begin
              if (cmd_op == scrf_pkg::OP_ENABLE) begin
                active_nxt[cmd_ch] = 1'b1;
              end else if (!family_r) begin
                if (cmd_op == scrf_pkg::OP_DIS_M0) begin
                  active_nxt[cmd_ch] = 1'b0;
                end
              end else if ((cmd_op == scrf_pkg::OP_DIS_M1_A) ||
                           (cmd_op == scrf_pkg::OP_DIS_M1_B)) begin
                active_nxt[cmd_ch] = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end else if (is_event && (32'(sel_ch) < N) && active_r[sel_ch] && link_r[sel_ch]) begin
      if (item.action == scrf_pkg::ACT_RX_DONE) begin
        if (enable_r[{2'b00, sel_ch, 1'b1}] && (rxf_r[sel_ch] != '0)) begin
          status_nxt[{3'b001, sel_ch}] = 1'b1;
          do_upd                       = 1'b1;
        end
      end else begin
        if (enable_r[{2'b00, sel_ch, 1'b0}] && (txf_r[sel_ch] != '0)) begin
          status_nxt[{3'b000, sel_ch}] = 1'b1;
          do_upd                       = 1'b1;
        end
      end
    end
  end

  // The line is raised while anything unmasked is pending; otherwise only
  // every third update with nothing pending drops it.
  always_comb begin
    cnt_inc   = cnt_r + 2'd1;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (do_upd) begin
      if ((status_nxt & mask_nxt) != '0) begin
        level_nxt = 1'b1;
      end else if (cnt_inc == 2'd3) begin
        level_nxt = 1'b0;
        cnt_nxt   = 2'd0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r <= 1'b0;
      link_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scrf_pkg::CFG_FAMILY: family_r <= cfg_wdata[0];
        scrf_pkg::CFG_LINK:   link_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      mask_r   <= '0;
      cnt_r    <= '0;
      level_r  <= 1'b0;
      enable_r <= '0;
      option_r <= '0;
      active_r <= '0;
      for (int i = 0; i < N; i++) begin
        crc_r[i]  <= '0;
        csh_r[i]  <= '0;
        cdiv_r[i] <= '0;
        txf_r[i]  <= '0;
        txl_r[i]  <= '0;
        rxf_r[i]  <= '0;
        rxl_r[i]  <= '0;
      end
    end else if (load) begin
      status_r <= status_nxt;
      mask_r   <= mask_nxt;
      cnt_r    <= cnt_nxt;
      level_r  <= level_nxt;
      enable_r <= enable_nxt;
      option_r <= option_nxt;
      active_r <= active_nxt;
      crc_r    <= crc_nxt;
      csh_r    <= csh_nxt;
      cdiv_r   <= cdiv_nxt;
      txf_r    <= txf_nxt;
      txl_r    <= txl_nxt;
      rxf_r    <= rxf_nxt;
      rxl_r    <= rxl_nxt;
    end
  end

  assign result.read_data = rd;
  assign result.irq_line  = level_nxt;

  assign irq_stat.irq_level = level_r;
  assign irq_stat.pending   = ((status_r & mask_r) != '0);
  assign irq_stat.clear_cnt = cnt_r;

endmodule

[hw/rtl/scrf_out_reg.sv]
module scrf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  scrf_pkg::result_t result,
  output logic              advance,
  output logic              load,
  output logic              res_valid,
  input  logic              res_ready,
  output scrf_pkg::result_t res_data
);

  logic              out_v_r, out_v_nxt;
  scrf_pkg::result_t res_r;

  assign advance   = !out_v_r || res_ready;
  assign load      = item_valid && advance;
  assign out_v_nxt = advance ? item_valid : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
    if (load) begin
      res_r <= result;
    end
  end

  assign res_valid = out_v_r;
  assign res_data  = res_r;

endmodule
